@@ sv/cfr_pkg.sv @@
// Package: frame layout, codes and types shared by the command frame receiver.
`timescale 1ns / 1ps
package cfr_pkg;

  localparam int unsigned FRAME_LENGTH = 40;
  localparam logic [7:0] LAST_POS = 8'(FRAME_LENGTH - 1);
  localparam logic [7:0] SUM_POS  = 8'(FRAME_LENGTH - 2);

  localparam logic [7:0] POS_HEADER_0    = 8'd0;
  localparam logic [7:0] POS_HEADER_1    = 8'd1;
  localparam logic [7:0] POS_SERVO_ID    = 8'd3;
  localparam logic [7:0] POS_SERVO_CMD   = 8'd4;
  localparam logic [7:0] POS_SERVO_MODE  = 8'd5;
  localparam logic [7:0] POS_AZ_FIRST    = 8'd6;
  localparam logic [7:0] POS_AZ_LAST     = 8'd9;
  localparam logic [7:0] POS_PITCH_FIRST = 8'd10;
  localparam logic [7:0] POS_PITCH_LAST  = 8'd13;
  localparam logic [7:0] POS_CAMERA_ID   = 8'd18;
  localparam logic [7:0] POS_CAMERA_CMD  = 8'd19;
  localparam logic [7:0] POS_THR_FIRST   = 8'd20;
  localparam logic [7:0] POS_THR_LAST    = 8'd21;
  localparam logic [7:0] POS_OPTIONS     = 8'd22;
  localparam logic [7:0] POS_EXP_FIRST   = 8'd23;
  localparam logic [7:0] POS_EXP_LAST    = 8'd26;
  localparam logic [7:0] POS_GEOM_FIRST  = 8'd27;
  localparam logic [7:0] POS_GEOM_LAST   = 8'd34;
  localparam logic [7:0] POS_LASER_ID    = 8'd37;

  localparam logic [7:0] HEADER_BYTE_0 = 8'hEB;
  localparam logic [7:0] HEADER_BYTE_1 = 8'h90;
  localparam logic [7:0] TAIL_BYTE     = 8'hFE;
  localparam logic [7:0] CMD_SET       = 8'h55;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SUM    = 2'd1,
    ST_TAIL   = 2'd2,
    ST_HEADER = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  servo_id;
    logic [7:0]  servo_cmd;
    logic [7:0]  camera_id;
    logic [7:0]  camera_cmd;
    logic [7:0]  laser_id;
    logic        servo_set;
    logic        mode_valid;
    logic [4:0]  mode_code;
    logic        offset_load;
    logic [31:0] azimuth;
    logic [31:0] pitch;
    logic        camera_set;
    logic        algo;
    logic        win_valid;
    logic [1:0]  win_sel;
    logic [15:0] threshold;
    logic [31:0] exposure;
    logic [63:0] geometry;
  } cmd_t;

endpackage

@@ sv/cfr_if.sv @@
// Interfaces: byte input channel and frame result channel.
`timescale 1ns / 1ps
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_first;

  modport source (output valid, output rx_byte, output frame_first, input ready);
  modport sink (input valid, input rx_byte, input frame_first, output ready);
endinterface

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [23:0] station_ids;
  logic [7:0]  servo_command;
  logic [4:0]  op_mode;
  logic [31:0] azimuth_bits;
  logic [31:0] pitch_bits;
  logic        offset_load;
  logic [7:0]  cam_opcode;
  logic [15:0] threshold;
  logic [2:0]  camera_options;
  logic [31:0] exposure_ticks;
  logic [63:0] window_geometry;

  modport source (
    output valid, output frame_status, output station_ids, output servo_command,
    output op_mode, output azimuth_bits, output pitch_bits, output offset_load,
    output cam_opcode, output threshold, output camera_options,
    output exposure_ticks, output window_geometry, input ready
  );
  modport sink (
    input valid, input frame_status, input station_ids, input servo_command,
    input op_mode, input azimuth_bits, input pitch_bits, input offset_load,
    input cam_opcode, input threshold, input camera_options,
    input exposure_ticks, input window_geometry, output ready
  );
endinterface

@@ sv/command_frame_receiver.sv @@
// Top level: command frame receiver, front end, frame queue and commit back end.
// Takes one byte per cycle while the frame queue is not full; one result per FRAME_LENGTH bytes.
// A frame's result is registered in the frame queue, then in the result register.
// Two-entry frame queue between front and back; byte input stalls only when it is full.
// Reset clears position, checksum, header flag, queue and all held fields to zero.
// Shadow field registers are not reset; every field is written before commit.
`timescale 1ns / 1ps
module command_frame_receiver (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfr_in_if.sink    in_i,
  cfr_out_if.source out_o
);
  import cfr_pkg::*;

  logic push, full, pop, q_valid;
  cmd_t front_cmd, queue_cmd;

  cfr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  cfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd)
  );

  cfr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (queue_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

@@ sv/cfr_front.sv @@
// Front end: byte position, header and checksum tracking, field shadowing, frame classification.
`timescale 1ns / 1ps
module cfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfr_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output cfr_pkg::cmd_t cmd_o
);
  import cfr_pkg::*;

  localparam logic [7:0] MODE_SEL_A      = 8'd1;
  localparam logic [7:0] MODE_SEL_B      = 8'd4;
  localparam logic [7:0] MODE_SEL_C      = 8'd3;
  localparam logic [7:0] MODE_SEL_D      = 8'd5;
  localparam logic [7:0] MODE_SEL_OFFSET = 8'd2;
  localparam logic [4:0] SYS_MODE_A      = 5'd17;
  localparam logic [4:0] SYS_MODE_B      = 5'd3;
  localparam logic [4:0] SYS_MODE_C      = 5'd7;
  localparam logic [4:0] SYS_MODE_D      = 5'd1;
  localparam logic [7:0] WIN_MASK        = 8'h0C;
  localparam logic [7:0] WIN_CODE_SMALL  = 8'h04;
  localparam logic [7:0] WIN_CODE_LARGE  = 8'h08;
  localparam logic [1:0] WIN_SMALL       = 2'd1;
  localparam logic [1:0] WIN_LARGE       = 2'd2;

  logic        accept;
  logic [7:0]  rx;
  logic [7:0]  pos;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  recv_q, recv_d;
  logic        hdr_q, hdr_d;
  logic [7:0]  win_code;

  logic [7:0]  sv_id_q, sv_cmd_q, mode_q, cam_id_q, cam_cmd_q, opt_q, laser_q;
  logic [31:0] az_q, pitch_q, exp_q;
  logic [15:0] thr_q;
  logic [63:0] geom_q;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign rx         = in_i.rx_byte;
  assign pos        = in_i.frame_first ? 8'd0 : pos_q;
  assign push_o     = accept && (pos == LAST_POS);

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    recv_d = recv_q;
    hdr_d  = hdr_q;
    if (accept) begin
      if (pos == POS_HEADER_0) begin
        hdr_d = (rx == HEADER_BYTE_0);
        sum_d = 8'd0;
      end else if (pos == POS_HEADER_1) begin
        hdr_d = hdr_q && (rx == HEADER_BYTE_1);
      end else if (pos < SUM_POS) begin
        sum_d = sum_q + rx;
      end else if (pos == SUM_POS) begin
        recv_d = rx;
      end
      pos_d = (pos < LAST_POS) ? (pos + 8'd1) : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      recv_q <= '0;
      hdr_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      recv_q <= recv_d;
      hdr_q  <= hdr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      case (pos) inside
        POS_SERVO_ID:                    sv_id_q   <= rx;
        POS_SERVO_CMD:                   sv_cmd_q  <= rx;
        POS_SERVO_MODE:                  mode_q    <= rx;
        [POS_AZ_FIRST:POS_AZ_LAST]:      az_q      <= {az_q[23:0], rx};
        [POS_PITCH_FIRST:POS_PITCH_LAST]: pitch_q  <= {pitch_q[23:0], rx};
        POS_CAMERA_ID:                   cam_id_q  <= rx;
        POS_CAMERA_CMD:                  cam_cmd_q <= rx;
        [POS_THR_FIRST:POS_THR_LAST]:    thr_q     <= {thr_q[7:0], rx};
        POS_OPTIONS:                     opt_q     <= rx;
        [POS_EXP_FIRST:POS_EXP_LAST]:    exp_q     <= {exp_q[23:0], rx};
        [POS_GEOM_FIRST:POS_GEOM_LAST]:  geom_q    <= {geom_q[55:0], rx};
        POS_LASER_ID:                    laser_q   <= rx;
        default: ;
      endcase
    end
  end

  assign win_code = opt_q & WIN_MASK;

  always_comb begin
    if (!hdr_q) begin
      cmd_o.status = ST_HEADER;
    end else if (rx != TAIL_BYTE) begin
      cmd_o.status = ST_TAIL;
    end else if (sum_q != recv_q) begin
      cmd_o.status = ST_SUM;
    end else begin
      cmd_o.status = ST_OK;
    end
    cmd_o.servo_id    = sv_id_q;
    cmd_o.servo_cmd   = sv_cmd_q;
    cmd_o.camera_id   = cam_id_q;
    cmd_o.camera_cmd  = cam_cmd_q;
    cmd_o.laser_id    = laser_q;
    cmd_o.servo_set   = (sv_cmd_q == CMD_SET);
    cmd_o.mode_valid  = 1'b1;
    unique case (mode_q)
      MODE_SEL_A: cmd_o.mode_code = SYS_MODE_A;
      MODE_SEL_B: cmd_o.mode_code = SYS_MODE_B;
      MODE_SEL_C: cmd_o.mode_code = SYS_MODE_C;
      MODE_SEL_D: cmd_o.mode_code = SYS_MODE_D;
      default: begin
        cmd_o.mode_valid = 1'b0;
        cmd_o.mode_code  = 5'd0;
      end
    endcase
    cmd_o.offset_load = (mode_q == MODE_SEL_OFFSET);
    cmd_o.azimuth     = az_q;
    cmd_o.pitch       = pitch_q;
    cmd_o.camera_set  = (cam_cmd_q == CMD_SET);
    cmd_o.algo        = opt_q[0];
    cmd_o.win_valid   = 1'b1;
    unique case (win_code)
      WIN_CODE_SMALL: cmd_o.win_sel = WIN_SMALL;
      WIN_CODE_LARGE: cmd_o.win_sel = WIN_LARGE;
      default: begin
        cmd_o.win_valid = 1'b0;
        cmd_o.win_sel   = 2'd0;
      end
    endcase
    cmd_o.threshold   = thr_q;
    cmd_o.exposure    = exp_q;
    cmd_o.geometry    = geom_q;
  end

  a_push_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (pos_q == 8'd0))
    else $error("position did not wrap after frame end");

  a_push_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("frame pushed into full queue");

endmodule

@@ sv/cfr_queue.sv @@
// Queue: short FIFO of classified frames between front and back.
`timescale 1ns / 1ps
module cfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cfr_pkg::cmd_t cmd_o
);
  import cfr_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : (wr_q + QPTR_W'(1));
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : (rd_q + QPTR_W'(1));
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue underflow");

endmodule

@@ sv/cfr_back.sv @@
// Back end: commits classified frames into held fields and drives the result register.
`timescale 1ns / 1ps
module cfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  cfr_pkg::cmd_t cmd_i,
  output logic          pop_o,
  cfr_out_if.source     out_o
);
  import cfr_pkg::*;

  logic        valid_q;
  logic        commit;
  status_e     status_q;
  logic [23:0] ids_q;
  logic [7:0]  sv_cmd_q, cam_cmd_q;
  logic [4:0]  mode_q;
  logic [31:0] az_q, pitch_q, exp_q;
  logic        off_q;
  logic [15:0] thr_q;
  logic [2:0]  opt_q;
  logic [63:0] geom_q;

  assign pop_o  = q_valid_i && (!valid_q || out_o.ready);
  assign commit = pop_o && (cmd_i.status == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_q     <= '0;
      sv_cmd_q  <= '0;
      cam_cmd_q <= '0;
      mode_q    <= '0;
      az_q      <= '0;
      pitch_q   <= '0;
      off_q     <= 1'b0;
      thr_q     <= '0;
      opt_q     <= '0;
      exp_q     <= '0;
      geom_q    <= '0;
    end else if (commit) begin
      ids_q     <= {cmd_i.servo_id, cmd_i.camera_id, cmd_i.laser_id};
      sv_cmd_q  <= cmd_i.servo_cmd;
      cam_cmd_q <= cmd_i.camera_cmd;
      if (cmd_i.servo_set) begin
        if (cmd_i.mode_valid) begin
          mode_q <= cmd_i.mode_code;
        end
        az_q    <= cmd_i.azimuth;
        pitch_q <= cmd_i.pitch;
        off_q   <= cmd_i.offset_load;
      end
      if (cmd_i.camera_set) begin
        opt_q[0] <= cmd_i.algo;
        if (cmd_i.win_valid) begin
          opt_q[2:1] <= cmd_i.win_sel;
        end
        thr_q  <= cmd_i.threshold;
        exp_q  <= cmd_i.exposure;
        geom_q <= cmd_i.geometry;
      end
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.frame_status    = status_q;
  assign out_o.station_ids     = ids_q;
  assign out_o.servo_command   = sv_cmd_q;
  assign out_o.op_mode         = mode_q;
  assign out_o.azimuth_bits    = az_q;
  assign out_o.pitch_bits      = pitch_q;
  assign out_o.offset_load     = off_q;
  assign out_o.cam_opcode      = cam_cmd_q;
  assign out_o.threshold       = thr_q;
  assign out_o.camera_options  = opt_q;
  assign out_o.exposure_ticks  = exp_q;
  assign out_o.window_geometry = geom_q;

  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("popped frame not presented");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_o.ready) |=> ($stable(status_q) && $stable(ids_q) && $stable(geom_q)))
    else $error("result changed while stalled");

  a_bad_frame_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (cmd_i.status != ST_OK)) |=> ($stable(ids_q) && $stable(mode_q)))
    else $error("bad frame altered held fields");

endmodule

@@ tb/tb.sv @@
// Testbench: command frame receiver fed byte frames and checked per frame against a predictor.
`timescale 1ns / 1ps
module tb;
  import cfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 100000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned HOLD_AT       = 800;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MIXED_ROUNDS  = 18;
  localparam int unsigned CALM_ROUNDS   = 10;

  localparam logic [7:0] CMD_QUERY         = 8'hAA;
  localparam logic [7:0] CAM_FACTORY_RESET = 8'h66;
  localparam logic [7:0] CAM_SAVE          = 8'h67;

  localparam logic [7:0] REQ_MODE_1      = 8'd1;
  localparam logic [7:0] REQ_MODE_OFFSET = 8'd2;
  localparam logic [7:0] REQ_MODE_3      = 8'd3;
  localparam logic [7:0] REQ_MODE_4      = 8'd4;
  localparam logic [7:0] REQ_MODE_5      = 8'd5;
  localparam logic [7:0] REQ_MODE_NONE   = 8'd7;
  localparam logic [4:0] SYS_MODE_FROM_1 = 5'd17;
  localparam logic [4:0] SYS_MODE_FROM_3 = 5'd7;
  localparam logic [4:0] SYS_MODE_FROM_4 = 5'd3;
  localparam logic [4:0] SYS_MODE_FROM_5 = 5'd1;

  localparam logic [7:0] WIN_SEL_MASK  = 8'h0C;
  localparam logic [7:0] WIN_SEL_SMALL = 8'h04;
  localparam logic [7:0] WIN_SEL_LARGE = 8'h08;
  localparam logic [7:0] ALGO_BIT      = 8'h01;
  localparam logic [1:0] WIN_SMALL     = 2'd1;
  localparam logic [1:0] WIN_LARGE     = 2'd2;

  localparam logic [3:0] NO_FLAW   = 4'b0000;
  localparam logic [3:0] FLAW_HDR0 = 4'b0001;
  localparam logic [3:0] FLAW_HDR1 = 4'b0010;
  localparam logic [3:0] FLAW_TAIL = 4'b0100;
  localparam logic [3:0] FLAW_SUM  = 4'b1000;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } byte_item_t;

  typedef struct packed {
    status_e     status;
    logic [23:0] ids;
    logic [7:0]  servo_cmd;
    logic [4:0]  mode;
    logic [31:0] azimuth;
    logic [31:0] pitch;
    logic        offset;
    logic [7:0]  cam_cmd;
    logic [15:0] threshold;
    logic [2:0]  options;
    logic [31:0] exposure;
    logic [63:0] geometry;
  } frame_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cfr_in_if  in_bus ();
  cfr_out_if out_bus ();

  command_frame_receiver uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  byte_item_t    byte_q[$];
  frame_result_t frame_q[$];
  logic [7:0]    frame_buf [0:FRAME_LENGTH-1];

  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned bytes_sent = 0;
  int unsigned hold_left  = 0;
  int unsigned src_gap    = 0;
  int unsigned sink_gap   = 0;
  logic        hold_done  = 1'b0;
  logic        calm       = 1'b0;
  logic        in_sync    = 1'b1;
  logic        byte_taken = 1'b0;

  // predictor state
  logic [7:0]  pos_m      = '0;
  logic [7:0]  sum_m      = '0;
  logic [7:0]  sum_byte_m = '0;
  logic        hdr_ok_m   = 1'b0;
  logic [7:0]  shadow_m [0:FRAME_LENGTH-1];
  logic [4:0]  held_mode   = '0;
  logic [23:0] held_ids    = '0;
  logic [7:0]  held_scmd   = '0;
  logic [7:0]  held_ccmd   = '0;
  logic        held_offset = 1'b0;
  logic [31:0] held_az     = '0;
  logic [31:0] held_pitch  = '0;
  logic [15:0] held_thr    = '0;
  logic [2:0]  held_opts   = '0;
  logic [31:0] held_exp    = '0;
  logic [63:0] held_geom   = '0;

  function automatic logic [63:0] shadow_word(input logic [7:0] start, input int unsigned count);
    logic [63:0] acc;
    acc = '0;
    for (int unsigned k = 0; k < count; k++) acc = {acc[55:0], shadow_m[start + k]};
    return acc;
  endfunction

  task automatic commit_frame();
    logic [7:0] scmd;
    logic [7:0] ccmd;
    logic [7:0] smode;
    logic [7:0] copt;
    logic [1:0] win;
    scmd  = shadow_m[POS_SERVO_CMD];
    ccmd  = shadow_m[POS_CAMERA_CMD];
    smode = shadow_m[POS_SERVO_MODE];
    copt  = shadow_m[POS_OPTIONS];
    if (scmd == CMD_SET) begin
      case (smode)
        REQ_MODE_1: held_mode = SYS_MODE_FROM_1;
        REQ_MODE_3: held_mode = SYS_MODE_FROM_3;
        REQ_MODE_4: held_mode = SYS_MODE_FROM_4;
        REQ_MODE_5: held_mode = SYS_MODE_FROM_5;
        default: ;
      endcase
      held_az     = 32'(shadow_word(POS_AZ_FIRST, 4));
      held_pitch  = 32'(shadow_word(POS_PITCH_FIRST, 4));
      held_offset = (smode == REQ_MODE_OFFSET);
    end
    held_ids  = {shadow_m[POS_SERVO_ID], shadow_m[POS_CAMERA_ID], shadow_m[POS_LASER_ID]};
    held_scmd = scmd;
    held_ccmd = ccmd;
    if (ccmd == CMD_SET) begin
      win = held_opts[2:1];
      if ((copt & WIN_SEL_MASK) == WIN_SEL_SMALL) win = WIN_SMALL;
      else if ((copt & WIN_SEL_MASK) == WIN_SEL_LARGE) win = WIN_LARGE;
      held_opts = {win, copt[0]};
      held_thr  = 16'(shadow_word(POS_THR_FIRST, 2));
      held_exp  = 32'(shadow_word(POS_EXP_FIRST, 4));
      held_geom = shadow_word(POS_GEOM_FIRST, 8);
    end
  endtask

  task automatic track_byte(input logic [7:0] data, input logic first);
    logic [7:0] p;
    status_e    st;
    if (first) pos_m = '0;
    p = pos_m;
    shadow_m[p] = data;
    if (p == POS_HEADER_0) begin
      hdr_ok_m = (data == HEADER_BYTE_0);
      sum_m = '0;
    end else if (p == POS_HEADER_1) begin
      hdr_ok_m = hdr_ok_m && (data == HEADER_BYTE_1);
    end else if (p < SUM_POS) begin
      sum_m = sum_m + data;
    end else if (p == SUM_POS) begin
      sum_byte_m = data;
    end
    if (p == LAST_POS) begin
      pos_m = '0;
      if (!hdr_ok_m) st = ST_HEADER;
      else if (data != TAIL_BYTE) st = ST_TAIL;
      else if (sum_m != sum_byte_m) st = ST_SUM;
      else st = ST_OK;
      if (st == ST_OK) commit_frame();
      frame_q.push_back('{st, held_ids, held_scmd, held_mode, held_az, held_pitch, held_offset,
                          held_ccmd, held_thr, held_opts, held_exp, held_geom});
    end else begin
      pos_m = p + 8'd1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_frame_result();
    frame_result_t want;
    if (frame_q.size() == 0) begin
      report_mismatch($sformatf("result with status %0d and none pending",
                                out_bus.frame_status));
    end else begin
      want = frame_q.pop_front();
      check_field("frame_status", 64'(out_bus.frame_status), 64'(want.status));
      check_field("station_ids", 64'(out_bus.station_ids), 64'(want.ids));
      check_field("servo_command", 64'(out_bus.servo_command), 64'(want.servo_cmd));
      check_field("op_mode", 64'(out_bus.op_mode), 64'(want.mode));
      check_field("azimuth_bits", 64'(out_bus.azimuth_bits), 64'(want.azimuth));
      check_field("pitch_bits", 64'(out_bus.pitch_bits), 64'(want.pitch));
      check_field("offset_load", 64'(out_bus.offset_load), 64'(want.offset));
      check_field("cam_opcode", 64'(out_bus.cam_opcode), 64'(want.cam_cmd));
      check_field("threshold", 64'(out_bus.threshold), 64'(want.threshold));
      check_field("camera_options", 64'(out_bus.camera_options), 64'(want.options));
      check_field("exposure_ticks", 64'(out_bus.exposure_ticks), 64'(want.exposure));
      check_field("window_geometry", out_bus.window_geometry, want.geometry);
    end
  endtask

  task automatic send_frame(input logic [7:0] scmd, input logic [7:0] smode,
                            input logic [7:0] ccmd, input logic [7:0] copt, input fill_e fill,
                            input logic [3:0] flaws, input logic mark_first);
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < FRAME_LENGTH; i++) begin
      case (fill)
        FILL_ZERO: frame_buf[i] = 8'h00;
        FILL_ONES: frame_buf[i] = 8'hFF;
        default:   frame_buf[i] = 8'($urandom);
      endcase
    end
    frame_buf[POS_HEADER_0]   = HEADER_BYTE_0;
    frame_buf[POS_HEADER_1]   = HEADER_BYTE_1;
    frame_buf[POS_SERVO_CMD]  = scmd;
    frame_buf[POS_SERVO_MODE] = smode;
    frame_buf[POS_CAMERA_CMD] = ccmd;
    frame_buf[POS_OPTIONS]    = copt;
    frame_buf[LAST_POS]       = TAIL_BYTE;
    for (int i = POS_HEADER_1 + 1; i < SUM_POS; i++) sum = sum + frame_buf[i];
    frame_buf[SUM_POS] = sum;
    if ((flaws & FLAW_HDR0) != 0) frame_buf[POS_HEADER_0] ^= 8'($urandom_range(1, 255));
    if ((flaws & FLAW_HDR1) != 0) frame_buf[POS_HEADER_1] ^= 8'($urandom_range(1, 255));
    if ((flaws & FLAW_TAIL) != 0) frame_buf[LAST_POS] ^= 8'($urandom_range(1, 255));
    if ((flaws & FLAW_SUM) != 0) frame_buf[SUM_POS] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < FRAME_LENGTH; i++)
      byte_q.push_back('{data: frame_buf[i], first: (i == 0) ? mark_first : 1'b0});
  endtask

  task automatic push_noise(input int unsigned count, input logic lead_first);
    for (int unsigned i = 0; i < count; i++)
      byte_q.push_back('{data: 8'($urandom),
                         first: (i == 0) ? lead_first : ($urandom_range(0, 7) == 0)});
  endtask

  task automatic random_frame(input logic mark_first);
    logic [7:0] scmd;
    logic [7:0] smode;
    logic [7:0] ccmd;
    logic [3:0] flaws;
    case ($urandom_range(0, 3)) inside
      0, 1:    scmd = CMD_SET;
      2:       scmd = CMD_QUERY;
      default: scmd = 8'($urandom);
    endcase
    case ($urandom_range(0, 4)) inside
      0, 1:    ccmd = CMD_SET;
      2:       ccmd = CAM_FACTORY_RESET;
      3:       ccmd = CAM_SAVE;
      default: ccmd = 8'($urandom);
    endcase
    smode = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    flaws = NO_FLAW;
    if ($urandom_range(0, 7) == 0) flaws = 4'(1 << $urandom_range(0, 3));
    send_frame(scmd, smode, ccmd, 8'($urandom), FILL_RANDOM, flaws, mark_first);
  endtask

  task automatic random_round();
    case ($urandom_range(0, 9))
      0: begin
        push_noise($urandom_range(1, 60), 1'($urandom_range(0, 1)));
        in_sync = 1'b0;
      end
      1: begin
        push_noise($urandom_range(5, 35), 1'b1);
        random_frame(1'b1);
        in_sync = 1'b1;
      end
      default: begin
        random_frame(in_sync ? 1'($urandom_range(0, 1)) : 1'b1);
        in_sync = 1'b1;
      end
    endcase
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || frame_q.size() != 0) @(posedge clk_i);
  endtask

  // byte driver
  always @(negedge clk_i) begin : feed
    logic offer;
    offer = 1'b0;
    if (!rst_ni) begin
      in_bus.valid       <= 1'b0;
      in_bus.rx_byte     <= '0;
      in_bus.frame_first <= 1'b0;
    end else if (!in_bus.valid || byte_taken) begin
      if (byte_taken) begin
        byte_q.delete(0);
        bytes_sent++;
      end
      if (src_gap != 0) begin
        src_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 3);
      end else begin
        offer = (byte_q.size() != 0);
      end
      in_bus.valid <= offer;
      if (offer) begin
        in_bus.rx_byte     <= byte_q[0].data;
        in_bus.frame_first <= byte_q[0].first;
      end
    end
  end

  // long hold-off on the result side
  always @(posedge clk_i) begin
    if (!hold_done && bytes_sent >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      out_bus.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 3);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_taken = 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_frame_result();
      byte_taken = in_bus.valid && in_bus.ready;
      if (byte_taken) track_byte(in_bus.rx_byte, in_bus.frame_first);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    send_frame(CMD_SET, REQ_MODE_1, CMD_SET, WIN_SEL_SMALL, FILL_ZERO, NO_FLAW, 1'b1);
    send_frame(CMD_SET, REQ_MODE_4, CMD_SET, WIN_SEL_LARGE | ALGO_BIT, FILL_ONES, NO_FLAW, 1'b1);
    // the next two frames start without a frame marker
    send_frame(CMD_SET, REQ_MODE_3, CAM_FACTORY_RESET, 8'($urandom), FILL_RANDOM, NO_FLAW, 1'b0);
    send_frame(CMD_SET, REQ_MODE_5, CAM_SAVE, 8'($urandom), FILL_RANDOM, NO_FLAW, 1'b0);
    send_frame(CMD_SET, REQ_MODE_OFFSET, CMD_SET, WIN_SEL_MASK, FILL_RANDOM, NO_FLAW, 1'b1);
    send_frame(CMD_SET, REQ_MODE_NONE, CMD_SET, 8'h00, FILL_RANDOM, NO_FLAW, 1'b1);
    send_frame(CMD_QUERY, REQ_MODE_1, CMD_SET, 8'hFF, FILL_RANDOM, NO_FLAW, 1'b1);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, FILL_ONES, NO_FLAW, 1'b1);
    send_frame(CMD_SET, REQ_MODE_4, CMD_SET, 8'($urandom), FILL_RANDOM, FLAW_HDR0, 1'b1);
    send_frame(CMD_SET, REQ_MODE_4, CMD_SET, 8'($urandom), FILL_RANDOM, FLAW_HDR1, 1'b1);
    send_frame(CMD_SET, REQ_MODE_4, CMD_SET, 8'($urandom), FILL_RANDOM, FLAW_TAIL, 1'b1);
    send_frame(CMD_SET, REQ_MODE_4, CMD_SET, 8'($urandom), FILL_RANDOM, FLAW_SUM, 1'b1);
    send_frame(CMD_SET, REQ_MODE_3, CMD_SET, 8'($urandom), FILL_RANDOM,
               FLAW_HDR0 | FLAW_TAIL, 1'b1);
    send_frame(CMD_SET, REQ_MODE_3, CMD_SET, 8'($urandom), FILL_RANDOM,
               FLAW_TAIL | FLAW_SUM, 1'b1);
    // drop a partial frame by restarting
    push_noise(17, 1'b1);
    send_frame(CMD_SET, REQ_MODE_5, CMD_SET, 8'($urandom), FILL_RANDOM, NO_FLAW, 1'b1);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // hold the sender until every result is back
    wait_drained();
    repeat (MIXED_ROUNDS) random_round();
    while (byte_q.size() != 0) @(posedge clk_i);
    calm = 1'b1;
    repeat (CALM_ROUNDS) random_round();
    random_frame(1'b1);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
